@@ design/rs_pkg.sv @@
// shared constants, register indexes and the random step for the reservoir sampler
`timescale 1ns / 1ps
`default_nettype none

package rs_pkg;

    localparam int unsigned COUNT_W = 32;

    // the item count stops here, so count plus one never wraps
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFE;

    localparam logic [COUNT_W-1:0] GEN_RESET = 32'd1;

    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SEED_VALUE  = 1'b0;
    localparam cfg_index_t REG_SIZE_IN_USE = 1'b1;

    typedef logic [0:0] command_t;

    localparam command_t CMD_PUSH = 1'b0;
    localparam command_t CMD_READ = 1'b1;

    // one xorshift step
    function automatic logic [COUNT_W-1:0] xorshift_step(input logic [COUNT_W-1:0] x);
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

`default_nettype wire

@@ design/reservoir_sampler.sv @@
// reservoir sampler top level: sequencer, count, generator and slot store
//
// Algorithm R reservoir sampler. A push word fills the next slot until
// size_in_use words have been seen; after that each push steps a 32-bit
// xorshift generator and takes its value modulo count plus one in a
// bit-serial remainder unit, replacing that slot when the draw lands below
// size_in_use. A read returns the slot at read_index, valid below the fill
// level. One word is handled at a time: a read passes S_READ, a push
// during the fill phase S_WRITE, a push after that phase S_DRAW, S_DIVIDE
// (the remainder unit retires one bit of the 32-bit dividend per cycle)
// and S_WRITE, each then S_RESULT. A finished result waits in the output
// register while the next word is taken in. The slot store comes up
// undefined; read_valid is set only for a read_index below the fill level.
`timescale 1ns / 1ps
`default_nettype none

module reservoir_sampler
    import rs_pkg::*;
#(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                                             clk,
    input  wire logic                                             rst_n,
    input  wire logic                                             cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]                           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                            cfg_data,
    input  wire logic                                             in_valid,
    output logic                                                  in_stall,
    input  wire logic                                             command,
    input  wire logic [DATA_WIDTH-1:0]                            item_data,
    input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] read_index,
    output logic                                                  out_valid,
    input  wire logic                                             out_stall,
    output logic                                                  stored,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0]      stored_slot,
    output logic [DATA_WIDTH-1:0]                                 read_data,
    output logic                                                  read_valid,
    output logic [$clog2(CAPACITY + 1)-1:0]                       fill_level
);

    localparam int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned SW       = $clog2(CAPACITY + 1);
    localparam int unsigned SIZE_RST = (CAPACITY < 64) ? CAPACITY : 64;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_DRAW   = 6'b000100,
        S_DIVIDE = 6'b001000,
        S_WRITE  = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    gen_reg;
    logic [SW-1:0]         size_reg;
    logic [COUNT_W-1:0]    pos_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic [AW-1:0]         idx_reg;
    logic                  is_read_reg;
    logic                  hit_reg;
    logic [AW-1:0]         slot_reg;

    logic                  out_valid_reg;
    logic                  stored_out_reg;
    logic [AW-1:0]         slot_out_reg;
    logic [DATA_WIDTH-1:0] rdata_out_reg;
    logic                  rvalid_out_reg;
    logic [SW-1:0]         fill_out_reg;

    logic                  accept;
    logic [SW-1:0]         eff_size;
    logic [SW-1:0]         fill_now;
    logic                  read_ok;
    logic                  pos_hit;
    logic                  result_load;
    logic [COUNT_W-1:0]    gen_step;
    logic                  div_done;
    logic [COUNT_W-1:0]    div_rem;
    logic [DATA_WIDTH-1:0] ram_rdata;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign result_load = (state_reg == S_RESULT) && (!out_valid_reg || !out_stall);
    assign gen_step    = xorshift_step(gen_reg);

    // size zero acts as one, anything past capacity as capacity
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SW'(1);
        end
        else if (size_reg > SW'(CAPACITY))
        begin
            eff_size = SW'(CAPACITY);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    always_comb
    begin
        if (count_reg < COUNT_W'(eff_size))
        begin
            fill_now = count_reg[SW-1:0];
        end
        else
        begin
            fill_now = eff_size;
        end
    end

    assign read_ok = (COUNT_W'(idx_reg) < COUNT_W'(fill_now));
    assign pos_hit = (pos_reg < COUNT_W'(eff_size));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (count_reg < COUNT_W'(eff_size))
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
            end
            S_READ:   state_next = S_RESULT;
            S_DRAW:   state_next = S_DIVIDE;
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:  state_next = S_RESULT;
            S_RESULT:
            begin
                if (result_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            gen_reg   <= GEN_RESET;
            size_reg  <= SW'(SIZE_RST);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SEED_VALUE:
                    begin
                        // xorshift locks up at zero
                        if (cfg_data == '0)
                        begin
                            gen_reg <= GEN_RESET;
                        end
                        else
                        begin
                            gen_reg <= cfg_data[COUNT_W-1:0];
                        end
                    end
                    REG_SIZE_IN_USE:
                    begin
                        size_reg <= cfg_data[SW-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_DRAW)
            begin
                gen_reg <= gen_step;
            end
            if ((state_reg == S_WRITE) && (count_reg < COUNT_MAX))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // working copy of the word and the slot decision
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg    <= item_data;
            idx_reg     <= read_index;
            is_read_reg <= (command == CMD_READ);
            pos_reg     <= count_reg;
            hit_reg     <= 1'b0;
            slot_reg    <= '0;
        end
        if ((state_reg == S_DIVIDE) && div_done)
        begin
            pos_reg <= div_rem;
        end
        if (state_reg == S_WRITE)
        begin
            hit_reg <= pos_hit;
            if (pos_hit)
            begin
                slot_reg <= pos_reg[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            stored_out_reg <= hit_reg;
            slot_out_reg   <= slot_reg;
            fill_out_reg   <= fill_now;
            if (is_read_reg && read_ok)
            begin
                rvalid_out_reg <= 1'b1;
                rdata_out_reg  <= ram_rdata;
            end
            else
            begin
                rvalid_out_reg <= 1'b0;
                rdata_out_reg  <= '0;
            end
        end
    end

    rs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_DRAW),
        .dividend  (gen_step),
        .divisor   (count_reg + 1'b1),
        .done      (div_done),
        .remainder (div_rem)
    );

    rs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    ((state_reg == S_WRITE) && pos_hit),
        .waddr (pos_reg[AW-1:0]),
        .wdata (data_reg),
        .re    (state_reg == S_READ),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign stored      = stored_out_reg;
    assign stored_slot = slot_out_reg;
    assign read_data   = rdata_out_reg;
    assign read_valid  = rvalid_out_reg;
    assign fill_level  = fill_out_reg;

endmodule

`default_nettype wire

@@ design/rs_ram.sv @@
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ design/rs_mod_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rs_mod_unit
    import rs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [COUNT_W-1:0] dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output logic                    done,
    output logic      [COUNT_W-1:0] remainder
);

    localparam int unsigned STEP_W = $clog2(COUNT_W);

    logic               busy_reg;
    logic               done_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] dvd_reg;
    logic [COUNT_W-1:0] dsr_reg;

    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic [COUNT_W-1:0] rem_next;

    // borrow out of the subtract means the trial stays
    always_comb
    begin
        trial = {rem_reg, dvd_reg[COUNT_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (diff[COUNT_W])
        begin
            rem_next = trial[COUNT_W-1:0];
        end
        else
        begin
            rem_next = diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(COUNT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[COUNT_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
